[rtl/lmsd_pkg.sv]
// Package with the shared types and constants of the LED matrix scan driver.
`default_nettype none

package lmsd_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] SUBFRAME_LAST = 3'd6;

  typedef enum logic {
    OP_WRITE,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] pixel_row;
    logic [5:0] pixel_column;
    logic [7:0] pixel_value;
  } cmd_t;

  typedef struct packed {
    logic       red_top;
    logic       green_top;
    logic       blue_top;
    logic       red_bottom;
    logic       green_bottom;
    logic       blue_bottom;
    logic [5:0] out_column;
    logic [4:0] row_address;
    logic       last_column;
  } result_t;

  typedef struct packed {
    op_t        op;
    logic       bottom;
    logic [5:0] row;
    logic [5:0] column;
    logic [7:0] value;
  } entry_t;

endpackage

`default_nettype wire

[rtl/lmsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/lmsd_front.sv]
// Front end: accepts commands, drops out-of-range writes and classifies the rest.
`default_nettype none

module lmsd_front
  import lmsd_pkg::*;
#(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic   start,
  input  wire cmd_t   cmd,
  input  wire logic   full,
  input  wire logic   clearing,
  output logic        busy,
  output logic        push,
  output entry_t      entry
);

  localparam int HALF_ROWS = PANEL_HEIGHT / 2;
  localparam logic [7:0] ROW_LIMIT  = 8'(2 * HALF_ROWS);
  localparam logic [7:0] HALF_LIMIT = 8'(HALF_ROWS);
  localparam logic [8:0] COL_LIMIT  = 9'(PANEL_WIDTH);

  logic accept;
  logic in_range;
  logic bottom;

  always_comb begin
    busy     = full || clearing;
    accept   = start && !busy;
    in_range = ({2'b00, cmd.pixel_row} < ROW_LIMIT) &&
               ({3'b000, cmd.pixel_column} < COL_LIMIT);
    bottom   = {2'b00, cmd.pixel_row} >= HALF_LIMIT;
    push     = accept && (cmd.kind || in_range);

    entry.op     = cmd.kind ? OP_TICK : OP_WRITE;
    entry.bottom = bottom;
    entry.row    = bottom ? 6'({2'b00, cmd.pixel_row} - HALF_LIMIT) : cmd.pixel_row;
    entry.column = cmd.pixel_column;
    entry.value  = cmd.pixel_value;
  end

endmodule

`default_nettype wire

[rtl/lmsd_queue.sv]
// Short command queue between the front end and the scan engine.
`default_nettype none

module lmsd_queue
  import lmsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output logic        full,
  output logic        empty
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  always_comb begin
    full  = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    empty = count == '0;
    head  = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("transfer pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from an empty queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

[rtl/lmsd_back.sv]
// Scan engine: frame buffer clear, pixel writes and row-pair scan-out.
`default_nettype none

module lmsd_back
  import lmsd_pkg::*;
#(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire entry_t head,
  input  wire logic   empty,
  output logic        pop,
  output logic        clearing,
  output result_t     result,
  output logic        strobe
);

  localparam int HALF_ROWS = PANEL_HEIGHT / 2;
  localparam int DEPTH     = HALF_ROWS * PANEL_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(PANEL_WIDTH);
  localparam int RW        = $clog2(HALF_ROWS);

  back_state_t state, state_next;

  logic [AW-1:0] clr_addr;
  logic [CW-1:0] col;
  logic [AW-1:0] base;
  logic [RW-1:0] scan_row;
  logic [2:0]    subframe;
  logic [2:0]    scan_idx;
  logic          col_last;

  logic          rd_valid;
  logic          rd_last;
  logic [CW-1:0] rd_col;
  logic [RW-1:0] rd_row;

  logic          we_top, we_bot;
  logic [AW-1:0] waddr, raddr, wr_addr;
  logic [7:0]    wdata;
  logic [7:0]    pix_top, pix_bot;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    col_last   = col == CW'(PANEL_WIDTH - 1);
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.op == OP_TICK) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (col_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    clearing = state == ST_CLEAR;
    wr_addr  = AW'(32'(head.row) * 32'(PANEL_WIDTH) + 32'(head.column));
    waddr    = clearing ? clr_addr : wr_addr;
    wdata    = clearing ? 8'h00 : head.value;
    we_top   = clearing || (pop && head.op == OP_WRITE && !head.bottom);
    we_bot   = clearing || (pop && head.op == OP_WRITE && head.bottom);
    raddr    = base + AW'(col);
  end

  lmsd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_top (
    .clk   (clk),
    .we    (we_top),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (pix_top)
  );

  lmsd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_bot (
    .clk   (clk),
    .we    (we_bot),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (pix_bot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      scan_row <= '0;
      subframe <= '0;
      rd_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= 1'b0;
      strobe   <= rd_valid;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (pop && head.op == OP_TICK) begin
        scan_idx <= subframe;
        base     <= AW'(32'(scan_row) * 32'(PANEL_WIDTH));
        col      <= '0;
      end
      if (state == ST_SCAN) begin
        rd_valid <= 1'b1;
        col      <= col + 1'b1;
        if (col_last) begin
          if (scan_row == RW'(HALF_ROWS - 1)) begin
            scan_row <= '0;
            subframe <= (subframe == SUBFRAME_LAST) ? 3'd0 : subframe + 3'd1;
          end else begin
            scan_row <= scan_row + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_last <= col_last;
    rd_col  <= col;
    rd_row  <= scan_row;
    result.red_top      <= pix_top[7:5] > scan_idx;
    result.green_top    <= pix_top[4:2] > scan_idx;
    result.blue_top     <= pix_top[1:0] > scan_idx[2:1];
    result.red_bottom   <= pix_bot[7:5] > scan_idx;
    result.green_bottom <= pix_bot[4:2] > scan_idx;
    result.blue_bottom  <= pix_bot[1:0] > scan_idx[2:1];
    result.out_column   <= 6'(rd_col);
    result.row_address  <= rd_last ? 5'(rd_row) : 5'd0;
    result.last_column  <= rd_last;
  end

`ifndef SYNTHESIS
  a_scan_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_column |=> strobe)
    else $error("gap inside a row-pair scan");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_column |=> !strobe)
    else $error("result right after the last column");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_CLEAR) |-> !pop)
    else $error("queue popped while scanning or clearing");
`endif

endmodule

`default_nettype wire

[rtl/led_matrix_scan_pwm_driver.sv]
// Top level of the LED matrix scan driver with PWM sub-frames.
// After reset the frame buffer is cleared, one word of each half per cycle, and busy
// stays high until PANEL_HEIGHT/2 * PANEL_WIDTH words (2048 by default) are cleared.
// A pixel write is stored as the scan engine pops it and gives no result.
// A tick's results pass from the scan state through the RAM read and result registers,
// one per cycle for PANEL_WIDTH columns; the engine pops no command until the scan ends.
// Results cannot be stalled; a two-entry queue lets commands queue behind a scan.
`default_nettype none

module led_matrix_scan_pwm_driver
  import lmsd_pkg::*;
#(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output result_t   result,
  output logic      strobe
);

  logic   push, pop, full, empty, clearing;
  entry_t push_entry, head;

  lmsd_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .start    (start),
    .cmd      (cmd),
    .full     (full),
    .clearing (clearing),
    .busy     (busy),
    .push     (push),
    .entry    (push_entry)
  );

  lmsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  lmsd_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .clearing (clearing),
    .result   (result),
    .strobe   (strobe)
  );

endmodule

`default_nettype wire

[verif/led_matrix_scan_pwm_driver_test.sv]
// Testbench for the LED matrix scan driver: writes and ticks checked against a predictor.
`default_nettype none

module led_matrix_scan_pwm_driver_test;
  import lmsd_pkg::*;

  localparam int COLUMNS     = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CMDS = 350;
  localparam int CALM_FROM   = 300;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    cmd_t    cmd;
    logic    has_first;
    result_t first;
  } plan_row_t;

  localparam int PLAN_ROWS = 18;

  logic    clk;
  logic    rst;
  logic    start;
  cmd_t    cmd;
  logic    busy;
  result_t result;
  logic    strobe;

  logic [7:0] shadow_frame [0:4095];
  logic [4:0] shadow_row;
  logic [2:0] shadow_subframe;
  result_t    pending_columns [$];
  int         errors = 0;
  int         cycles = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{'{OP_WRITE, 6'd0,  6'd0,  8'hff}, 1'b0, '0},
    '{'{OP_WRITE, 6'd32, 6'd0,  8'hff}, 1'b0, '0},
    '{'{OP_WRITE, 6'd0,  6'd63, 8'he7}, 1'b0, '0},
    '{'{OP_WRITE, 6'd32, 6'd63, 8'h1f}, 1'b0, '0},
    '{'{OP_WRITE, 6'd0,  6'd1,  8'h00}, 1'b0, '0},
    '{'{OP_WRITE, 6'd32, 6'd1,  8'h03}, 1'b0, '0},
    '{'{OP_TICK,  6'd0,  6'd0,  8'h00}, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 6'd0, 5'd0, 1'b0}},
    '{'{OP_TICK,  6'd63, 6'd63, 8'hff}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 5'd0, 1'b0}},
    '{'{OP_WRITE, 6'd63, 6'd63, 8'hff}, 1'b0, '0},
    '{'{OP_WRITE, 6'd31, 6'd0,  8'he0}, 1'b0, '0},
    '{'{OP_WRITE, 6'd2,  6'd5,  8'h1c}, 1'b0, '0},
    '{'{OP_WRITE, 6'd34, 6'd5,  8'h03}, 1'b0, '0},
    '{'{OP_TICK,  6'd21, 6'd42, 8'h55}, 1'b0, '0},
    '{'{OP_WRITE, 6'd3,  6'd10, 8'h92}, 1'b0, '0},
    '{'{OP_WRITE, 6'd35, 6'd10, 8'h49}, 1'b0, '0},
    '{'{OP_TICK,  6'd42, 6'd21, 8'haa}, 1'b0, '0},
    '{'{OP_WRITE, 6'd4,  6'd62, 8'h6d}, 1'b0, '0},
    '{'{OP_TICK,  6'd0,  6'd0,  8'h00}, 1'b0, '0}
  };

  led_matrix_scan_pwm_driver i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .result (result),
    .strobe (strobe)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task report_mismatch(input string what, input int got, input int want);
    if (errors < PRINT_LIMIT)
      $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  task predict_command(input cmd_t c);
    logic [7:0] top_px;
    logic [7:0] bot_px;
    result_t    col;
    int         x;
    if (c.kind == OP_WRITE) begin
      shadow_frame[{c.pixel_row, c.pixel_column}] = c.pixel_value;
    end else begin
      if (shadow_subframe > SUBFRAME_LAST) shadow_subframe = '0;
      for (x = 0; x < COLUMNS; x++) begin
        top_px = shadow_frame[{1'b0, shadow_row, x[5:0]}];
        bot_px = shadow_frame[{1'b1, shadow_row, x[5:0]}];
        col.red_top      = top_px[7:5] > shadow_subframe;
        col.green_top    = top_px[4:2] > shadow_subframe;
        col.blue_top     = top_px[1:0] > shadow_subframe[2:1];
        col.red_bottom   = bot_px[7:5] > shadow_subframe;
        col.green_bottom = bot_px[4:2] > shadow_subframe;
        col.blue_bottom  = bot_px[1:0] > shadow_subframe[2:1];
        col.out_column   = x[5:0];
        col.last_column  = (x == COLUMNS - 1);
        col.row_address  = col.last_column ? shadow_row : 5'd0;
        pending_columns.push_back(col);
      end
      shadow_row = shadow_row + 5'd1;
      if (shadow_row == 5'd0)
        shadow_subframe = (shadow_subframe == SUBFRAME_LAST) ? 3'd0 : shadow_subframe + 3'd1;
    end
  endtask

  task transfer_command(input cmd_t c);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    predict_command(c);
  endtask

  task hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_columns.size() == 0) begin
        report_mismatch("result with none expected, column", result.out_column, -1);
      end else begin
        want = pending_columns.pop_front();
        if (result.red_top !== want.red_top)
          report_mismatch("red_top", result.red_top, want.red_top);
        if (result.green_top !== want.green_top)
          report_mismatch("green_top", result.green_top, want.green_top);
        if (result.blue_top !== want.blue_top)
          report_mismatch("blue_top", result.blue_top, want.blue_top);
        if (result.red_bottom !== want.red_bottom)
          report_mismatch("red_bottom", result.red_bottom, want.red_bottom);
        if (result.green_bottom !== want.green_bottom)
          report_mismatch("green_bottom", result.green_bottom, want.green_bottom);
        if (result.blue_bottom !== want.blue_bottom)
          report_mismatch("blue_bottom", result.blue_bottom, want.blue_bottom);
        if (result.out_column !== want.out_column)
          report_mismatch("out_column", result.out_column, want.out_column);
        if (result.row_address !== want.row_address)
          report_mismatch("row_address", result.row_address, want.row_address);
        if (result.last_column !== want.last_column)
          report_mismatch("last_column", result.last_column, want.last_column);
      end
    end
  end

  initial begin
    cmd_t c;
    int   i;
    shadow_row      = '0;
    shadow_subframe = '0;
    for (i = 0; i < 4096; i++) shadow_frame[i] = 8'h00;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_ROWS; i++) begin
      transfer_command(plan[i].cmd);
      if (plan[i].has_first)
        pending_columns[pending_columns.size() - COLUMNS] = plan[i].first;
    end

    for (i = 0; i < RANDOM_CMDS; i++) begin
      if (i == 60 || i == 150) begin
        hold_off(1);
        while (pending_columns.size() != 0) @(posedge clk);
      end
      if (i < CALM_FROM && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 7));
      c = cmd_t'($urandom);
      c.kind = ($urandom_range(0, 3) != 0) ? OP_TICK : OP_WRITE;
      if (c.kind == OP_WRITE) begin
        // aim half the writes at the row pair scanned next so they show up
        if ($urandom_range(0, 1) == 0) c.pixel_row = {c.pixel_row[5], shadow_row};
        case ($urandom_range(0, 7))
          0: c.pixel_value = 8'hff;
          1: c.pixel_value = 8'h00;
          default: ;
        endcase
      end
      transfer_command(c);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (COLUMNS + 8) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[led_matrix_scan_pwm_driver.f]
rtl/lmsd_pkg.sv
rtl/lmsd_ram.sv
rtl/lmsd_front.sv
rtl/lmsd_queue.sv
rtl/lmsd_back.sv
rtl/led_matrix_scan_pwm_driver.sv
verif/led_matrix_scan_pwm_driver_test.sv
